// ===== hw/rtl/brme_pkg.sv =====
`default_nettype none
package brme_pkg;

  // bitmap geometry
  localparam int MAX_BITS  = 4096;
  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int OFF_W     = $clog2(WORD_BITS);
  localparam int NWORDS_W  = ADDR_W + 1;

  // field widths
  localparam int CMD_W   = 3;
  localparam int BIT_W   = 12;
  localparam int COUNT_W = 13;
  localparam int WIDX_W  = 6;
  localparam int PROD_W  = COUNT_W + BIT_W;

  typedef enum logic [CMD_W-1:0] {
    CMD_MARK_ALL    = 3'd0,
    CMD_CLEAR_ALL   = 3'd1,
    CMD_MARK_RANGE  = 3'd2,
    CMD_CLEAR_RANGE = 3'd3,
    CMD_MARK_STRIDE = 3'd4,
    CMD_READ_WORD   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PCHK,
    ST_FILL,
    ST_RD,
    ST_WR,
    ST_RDATA,
    ST_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/brme_ram.sv =====
`default_nettype none
module brme_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/bitmap_range_mark_engine.sv =====
`default_nettype none
// channel   signals                                    dir  transfer when
// cmd in    in_valid, in_stall, cmd, start_bit,        in   in_valid && !in_stall
//           length, step, word_index
// result    out_valid, out_stall, read_data, status    out  out_valid && !out_stall
// config    cfg_valid, cfg_ready, bit_count            in   cfg_valid && cfg_ready
//
// one command at a time; the bitmap RAM (one write port, one registered read port)
// sets the pace: mark/clear all write one word per fill step, ranges read then write
// each word, and stride checks its last mark, then reads and writes each mark's word
// reset is synchronous; a per-word valid flag makes the whole map read as zero at once
// a stalled result sits in the output register while the next command is taken; the
// engine only holds in its final state if that register is still occupied
module bitmap_range_mark_engine (
  input  logic                            clk,
  input  logic                            rst,
  // command channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [brme_pkg::CMD_W-1:0]      cmd,
  input  logic [brme_pkg::BIT_W-1:0]      start_bit,
  input  logic [brme_pkg::COUNT_W-1:0]    length,
  input  logic [brme_pkg::BIT_W-1:0]      step,
  input  logic [brme_pkg::WIDX_W-1:0]     word_index,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [brme_pkg::WORD_BITS-1:0]  read_data,
  output logic                            status,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [brme_pkg::COUNT_W-1:0]    bit_count
);

  localparam logic [brme_pkg::WORD_BITS-1:0] ONES = '1;

  brme_pkg::state_t state, state_next;

  // configuration
  logic [brme_pkg::COUNT_W-1:0]   bit_limit;
  logic [brme_pkg::COUNT_W-1:0]   limit_clamped;

  // captured command
  brme_pkg::cmd_t                 op;
  logic [brme_pkg::BIT_W-1:0]     first_bit;
  logic [brme_pkg::COUNT_W-1:0]   span;
  logic [brme_pkg::BIT_W-1:0]     stride;
  logic [brme_pkg::WIDX_W-1:0]    widx;
  logic [brme_pkg::COUNT_W-1:0]   nbits;
  logic [brme_pkg::NWORDS_W-1:0]  nwords;

  // sequencer working registers
  logic [brme_pkg::ADDR_W-1:0]    word_cnt;
  logic [brme_pkg::BIT_W-1:0]     last_bit;
  logic [brme_pkg::BIT_W-1:0]     mark_idx;
  logic [brme_pkg::COUNT_W-1:0]   marks_left;
  logic [brme_pkg::PROD_W-1:0]    product;
  logic [brme_pkg::WORD_BITS-1:0] res_data;
  logic                           res_status;

  // per-word valid flags stand in for clearing the map at reset
  logic [brme_pkg::MAP_WORDS-1:0] word_valid;

  // bitmap RAM
  logic                           ram_we;
  logic [brme_pkg::ADDR_W-1:0]    ram_waddr;
  logic [brme_pkg::WORD_BITS-1:0] ram_wdata;
  logic [brme_pkg::ADDR_W-1:0]    ram_raddr;
  logic [brme_pkg::WORD_BITS-1:0] ram_rdata;

  // datapath helpers
  logic                           accept;
  logic                           out_free;
  logic [brme_pkg::COUNT_W:0]     range_sum;
  logic                           range_err;
  logic [brme_pkg::PROD_W:0]      stride_end;
  logic [brme_pkg::ADDR_W-1:0]    cur_word;
  logic [brme_pkg::WORD_BITS-1:0] cur_data;
  logic [brme_pkg::OFF_W-1:0]     lo_off;
  logic [brme_pkg::OFF_W-1:0]     hi_off;
  logic [brme_pkg::WORD_BITS-1:0] mod_mask;
  logic [brme_pkg::WORD_BITS-1:0] mod_data;
  logic [brme_pkg::WORD_BITS-1:0] tail_mask;
  logic [brme_pkg::WORD_BITS-1:0] fill_data;
  logic                           fill_last;
  logic                           wr_last;

  brme_ram #(
    .WIDTH(brme_pkg::WORD_BITS),
    .DEPTH(brme_pkg::MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign in_stall  = (state != brme_pkg::ST_IDLE);
  assign cfg_ready = (state == brme_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // counts above the map size act as the map size
  assign limit_clamped = (bit_limit > brme_pkg::COUNT_W'(brme_pkg::MAX_BITS))
                       ? brme_pkg::COUNT_W'(brme_pkg::MAX_BITS) : bit_limit;

  assign range_sum  = {1'b0, first_bit} + {1'b0, span};
  assign range_err  = range_sum > {1'b0, nbits};
  assign stride_end = (brme_pkg::PROD_W+1)'(first_bit) + {1'b0, product};

  // word under read-modify-write
  assign cur_word = (op == brme_pkg::CMD_MARK_STRIDE)
                  ? mark_idx[brme_pkg::BIT_W-1:brme_pkg::OFF_W] : word_cnt;
  assign cur_data = word_valid[cur_word] ? ram_rdata : '0;

  // range mask: partial head and tail words, whole words between
  assign lo_off = (word_cnt == first_bit[brme_pkg::BIT_W-1:brme_pkg::OFF_W])
                ? first_bit[brme_pkg::OFF_W-1:0] : '0;
  assign hi_off = (word_cnt == last_bit[brme_pkg::BIT_W-1:brme_pkg::OFF_W])
                ? last_bit[brme_pkg::OFF_W-1:0] : '1;

  always_comb begin
    if (op == brme_pkg::CMD_MARK_STRIDE) begin
      mod_mask = brme_pkg::WORD_BITS'(1) << mark_idx[brme_pkg::OFF_W-1:0];
    end else begin
      mod_mask = (ONES >> (brme_pkg::OFF_W'(brme_pkg::WORD_BITS - 1) - hi_off))
               & (ONES << lo_off);
    end
    if (op == brme_pkg::CMD_CLEAR_RANGE) begin
      mod_data = cur_data & ~mod_mask;
    end else begin
      mod_data = cur_data | mod_mask;
    end
  end

  assign wr_last = (op == brme_pkg::CMD_MARK_STRIDE)
                 ? (marks_left == brme_pkg::COUNT_W'(1))
                 : (word_cnt == last_bit[brme_pkg::BIT_W-1:brme_pkg::OFF_W]);

  // mark-all fill: last in-range word only gets the low bits
  assign tail_mask = (nbits[brme_pkg::OFF_W-1:0] == '0)
                   ? ONES : ~(ONES << nbits[brme_pkg::OFF_W-1:0]);
  assign fill_last = (brme_pkg::NWORDS_W'(word_cnt) == nwords - brme_pkg::NWORDS_W'(1));
  assign fill_data = (op == brme_pkg::CMD_CLEAR_ALL) ? '0
                   : (fill_last ? tail_mask : ONES);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= brme_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cur_word;
    ram_wdata  = mod_data;
    ram_raddr  = cur_word;
    unique case (state)
      brme_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = brme_pkg::ST_CHECK;
        end
      end
      brme_pkg::ST_CHECK: begin
        unique case (op)
          brme_pkg::CMD_MARK_ALL, brme_pkg::CMD_CLEAR_ALL: begin
            state_next = (nwords == '0) ? brme_pkg::ST_DONE : brme_pkg::ST_FILL;
          end
          brme_pkg::CMD_MARK_RANGE, brme_pkg::CMD_CLEAR_RANGE: begin
            state_next = (range_err || span == '0) ? brme_pkg::ST_DONE : brme_pkg::ST_RD;
          end
          brme_pkg::CMD_MARK_STRIDE: begin
            state_next = (span == '0 || stride == '0) ? brme_pkg::ST_DONE
                                                      : brme_pkg::ST_PCHK;
          end
          brme_pkg::CMD_READ_WORD: begin
            ram_raddr  = brme_pkg::ADDR_W'(widx);
            state_next = brme_pkg::ST_RDATA;
          end
          default: begin
            state_next = brme_pkg::ST_DONE;
          end
        endcase
      end
      brme_pkg::ST_PCHK: begin
        state_next = (stride_end >= (brme_pkg::PROD_W+1)'(nbits)) ? brme_pkg::ST_DONE
                                                                  : brme_pkg::ST_RD;
      end
      brme_pkg::ST_FILL: begin
        ram_we    = 1'b1;
        ram_waddr = word_cnt;
        ram_wdata = fill_data;
        if (fill_last) begin
          state_next = brme_pkg::ST_DONE;
        end
      end
      brme_pkg::ST_RD: begin
        state_next = brme_pkg::ST_WR;
      end
      brme_pkg::ST_WR: begin
        ram_we     = 1'b1;
        state_next = wr_last ? brme_pkg::ST_DONE : brme_pkg::ST_RD;
      end
      brme_pkg::ST_RDATA: begin
        state_next = brme_pkg::ST_DONE;
      end
      brme_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = brme_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = brme_pkg::ST_IDLE;
      end
    endcase
  end

  // configuration register and valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_limit  <= '0;
      word_valid <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bit_limit <= bit_count;
      end
      if (ram_we) begin
        word_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  // sequencer datapath
  always_ff @(posedge clk) begin
    unique case (state)
      brme_pkg::ST_IDLE: begin
        if (accept) begin
          op         <= brme_pkg::cmd_t'(cmd);
          first_bit  <= start_bit;
          span       <= length;
          stride     <= step;
          widx       <= word_index;
          nbits      <= limit_clamped;
          nwords     <= brme_pkg::NWORDS_W'(({1'b0, limit_clamped}
                        + (brme_pkg::COUNT_W+1)'(brme_pkg::WORD_BITS - 1))
                        >> brme_pkg::OFF_W);
          res_data   <= '0;
          res_status <= 1'b0;
        end
      end
      brme_pkg::ST_CHECK: begin
        // ranges start at the head word, fills at word zero
        word_cnt   <= (op == brme_pkg::CMD_MARK_RANGE || op == brme_pkg::CMD_CLEAR_RANGE)
                    ? first_bit[brme_pkg::BIT_W-1:brme_pkg::OFF_W] : '0;
        mark_idx   <= first_bit;
        marks_left <= span;
        last_bit   <= brme_pkg::BIT_W'(range_sum - (brme_pkg::COUNT_W+1)'(1));
        product    <= brme_pkg::PROD_W'(span - brme_pkg::COUNT_W'(1))
                    * brme_pkg::PROD_W'(stride);
        if ((op == brme_pkg::CMD_MARK_RANGE || op == brme_pkg::CMD_CLEAR_RANGE)
            && range_err) begin
          res_status <= 1'b1;
        end
        if (op == brme_pkg::CMD_MARK_STRIDE && span != '0 && stride == '0) begin
          res_status <= 1'b1;
        end
      end
      brme_pkg::ST_PCHK: begin
        if (stride_end >= (brme_pkg::PROD_W+1)'(nbits)) begin
          res_status <= 1'b1;
        end
      end
      brme_pkg::ST_FILL: begin
        word_cnt <= word_cnt + brme_pkg::ADDR_W'(1);
      end
      brme_pkg::ST_WR: begin
        word_cnt   <= word_cnt + brme_pkg::ADDR_W'(1);
        mark_idx   <= mark_idx + stride;
        marks_left <= marks_left - brme_pkg::COUNT_W'(1);
      end
      brme_pkg::ST_RDATA: begin
        res_data <= word_valid[brme_pkg::ADDR_W'(widx)] ? ram_rdata : '0;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == brme_pkg::ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == brme_pkg::ST_DONE && out_free) begin
      read_data <= res_data;
      status    <= res_status;
    end
  end

endmodule
`default_nettype wire
